### hdl/circle_zone_evaluator_macros.svh
// ----------------------------------------------------------------------------
// circle zone evaluator assertion macros
// shared concurrent check macros, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef CIRCLE_ZONE_EVALUATOR_MACROS_SVH
`define CIRCLE_ZONE_EVALUATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CZEV_CHECK(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("czev check failed");
`define CZEV_CHECK_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("czev implication failed");
`define CZEV_CHECK_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("czev next-cycle check failed");
`else
`define CZEV_CHECK(label, clk, rst_n, expr)
`define CZEV_CHECK_IMP(label, clk, rst_n, ante, cons)
`define CZEV_CHECK_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/czev_pkg.sv
// ----------------------------------------------------------------------------
// czev_pkg
// shared types and register codes of the circle zone evaluator
// ----------------------------------------------------------------------------
package czev_pkg;

    typedef enum logic [1:0] {
        CFG_CENTER_X      = 2'd0,
        CFG_CENTER_Y      = 2'd1,
        CFG_RADIUS        = 2'd2,
        CFG_BORDER_MARGIN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic on_border;
        logic inside_res;
    } t_flags;

endpackage

### hdl/czev_front.sv
// ----------------------------------------------------------------------------
// czev_front
// configuration registers, band squares, and the squared distance pipeline
// ----------------------------------------------------------------------------
`include "circle_zone_evaluator_macros.svh"

module czev_front #(
    parameter int CW = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  czev_pkg::t_cfg_idx      i_cfg_index,
    input  logic [CW-1:0]           i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CW-1:0]           i_pos_x,
    input  logic [CW-1:0]           i_pos_y,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2*CW+1:0]         o_rad,
    output czev_pkg::t_flags        o_flags,
    output logic [CW-2:0]           o_radius
);
    import czev_pkg::*;

    logic [CW-1:0]   r_cx, r_cy;
    logic [CW-2:0]   r_radius, r_margin;
    logic [CW-1:0]   r_outer;
    logic [CW-2:0]   r_inner;
    logic [2*CW-3:0] r_r2, r_i2;
    logic [2*CW-1:0] r_o2;

    logic [CW-3:0]   w_half;
    logic [CW-1:0]   n_outer;
    logic [CW-2:0]   n_inner;

    logic            r_va, r_vb, r_vc;
    logic            w_rdy_a, w_rdy_b, w_rdy_c;
    logic [CW-1:0]   r_dx, r_dy, n_dx, n_dy;
    logic [2*CW-1:0] r_sx, r_sy;
    logic [2*CW:0]   r_sum, w_sum;
    t_flags          r_flags, n_flags;

    logic signed [CW:0] w_dx, w_dy;
    logic [CW:0]        w_dx_neg, w_dy_neg;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_radius <= '0;
            r_margin <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_X:      r_cx     <= i_cfg_data;
                CFG_CENTER_Y:      r_cy     <= i_cfg_data;
                CFG_RADIUS:        r_radius <= i_cfg_data[CW-2:0];
                CFG_BORDER_MARGIN: r_margin <= i_cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // band radii and their squares
    assign w_half  = r_margin[CW-2:1];
    assign n_outer = CW'(r_radius) + CW'(w_half);
    assign n_inner = (r_radius > (CW-1)'(w_half)) ? (r_radius - (CW-1)'(w_half)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= '0;
            r_inner <= '0;
            r_r2    <= '0;
            r_o2    <= '0;
            r_i2    <= '0;
        end else begin
            r_outer <= n_outer;
            r_inner <= n_inner;
            r_r2    <= (2*CW-2)'(r_radius) * (2*CW-2)'(r_radius);
            r_o2    <= (2*CW)'(r_outer) * (2*CW)'(r_outer);
            r_i2    <= (2*CW-2)'(r_inner) * (2*CW-2)'(r_inner);
        end
    end

    // stage handshake
    assign w_rdy_c = !r_vc || i_ready;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_rdy_a) r_va <= i_valid;
            if (w_rdy_b) r_vb <= r_va;
            if (w_rdy_c) r_vc <= r_vb;
        end
    end

    // absolute coordinate differences
    assign w_dx     = $signed({i_pos_x[CW-1], i_pos_x}) - $signed({r_cx[CW-1], r_cx});
    assign w_dy     = $signed({i_pos_y[CW-1], i_pos_y}) - $signed({r_cy[CW-1], r_cy});
    assign w_dx_neg = -w_dx;
    assign w_dy_neg = -w_dy;
    assign n_dx     = w_dx[CW] ? w_dx_neg[CW-1:0] : w_dx[CW-1:0];
    assign n_dy     = w_dy[CW] ? w_dy_neg[CW-1:0] : w_dy[CW-1:0];

    // sum of squares and band tests
    assign w_sum = (2*CW+1)'(r_sx) + (2*CW+1)'(r_sy);
    always_comb begin
        n_flags.inside_res = (w_sum <= (2*CW+1)'(r_r2));
        n_flags.on_border  = (w_sum <= (2*CW+1)'(r_o2)) && (w_sum > (2*CW+1)'(r_i2));
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy_a) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (r_va && w_rdy_b) begin
            r_sx <= (2*CW)'(r_dx) * (2*CW)'(r_dx);
            r_sy <= (2*CW)'(r_dy) * (2*CW)'(r_dy);
        end
        if (r_vb && w_rdy_c) begin
            r_sum   <= w_sum;
            r_flags <= n_flags;
        end
    end

    assign o_valid  = r_vc;
    assign o_rad    = {1'b0, r_sum};
    assign o_flags  = r_flags;
    assign o_radius = r_radius;

    `CZEV_CHECK(a_inner_le_outer, i_clk, i_rst_n, CW'(r_inner) <= r_outer)
    `CZEV_CHECK(a_band_squares, i_clk, i_rst_n, (2*CW)'(r_i2) <= r_o2)
    `CZEV_CHECK_NXT(a_input_load, i_clk, i_rst_n, i_valid && w_rdy_a, r_va)

endmodule

### hdl/czev_root_cell.sv
// ----------------------------------------------------------------------------
// czev_root_cell
// one digit step of the floor square root, registered with its own handshake
// ----------------------------------------------------------------------------
`include "circle_zone_evaluator_macros.svh"

module czev_root_cell #(
    parameter int NB = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [NB:0]         i_rem,
    input  logic [NB-1:0]       i_root,
    input  logic [2*NB-1:0]     i_rad,
    input  czev_pkg::t_flags    i_flags,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [NB:0]         o_rem,
    output logic [NB-1:0]       o_root,
    output logic [2*NB-1:0]     o_rad,
    output czev_pkg::t_flags    o_flags
);
    import czev_pkg::*;

    logic              r_valid;
    logic [NB:0]       r_rem, n_rem;
    logic [NB-1:0]     r_root, n_root;
    logic [2*NB-1:0]   r_rad;
    t_flags            r_flags;

    logic [NB+2:0]     w_rem_sh, w_trial, w_diff;
    logic              w_ge;

    assign o_ready = !r_valid || i_ready;

    // bring down the next two radicand bits and try the next root bit
    assign w_rem_sh = {i_rem, i_rad[2*NB-1 -: 2]};
    assign w_trial  = (NB+3)'({i_root, 2'b01});
    assign w_diff   = w_rem_sh - w_trial;
    assign w_ge     = (w_rem_sh >= w_trial);
    assign n_rem    = w_ge ? w_diff[NB:0] : w_rem_sh[NB:0];
    assign n_root   = {i_root[NB-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem   <= n_rem;
            r_root  <= n_root;
            r_rad   <= {i_rad[2*NB-3:0], 2'b00};
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_flags = r_flags;

    `CZEV_CHECK_IMP(a_rem_bound, i_clk, i_rst_n, r_valid, r_rem <= {r_root, 1'b0})
    `CZEV_CHECK_NXT(a_cell_load, i_clk, i_rst_n, i_valid && o_ready, r_valid)
    `CZEV_CHECK_NXT(a_cell_hold, i_clk, i_rst_n, r_valid && !i_ready,
                    r_valid && $stable(r_root))

endmodule

### hdl/czev_back.sv
// ----------------------------------------------------------------------------
// czev_back
// distance to the circle and the output register
// ----------------------------------------------------------------------------
module czev_back #(
    parameter int NB = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [NB-1:0]       i_root,
    input  czev_pkg::t_flags    i_flags,
    input  logic [NB-3:0]       i_radius,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [NB-1:0]       o_distance,
    output czev_pkg::t_flags    o_flags
);
    import czev_pkg::*;

    logic            r_valid;
    logic [NB-1:0]   r_distance, n_distance;
    t_flags          r_flags;
    logic [NB-1:0]   w_radius;

    assign o_ready    = !r_valid || i_ready;
    assign w_radius   = NB'(i_radius);
    assign n_distance = (i_root >= w_radius) ? (i_root - w_radius) : (w_radius - i_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_distance <= n_distance;
            r_flags    <= i_flags;
        end
    end

    assign o_valid    = r_valid;
    assign o_distance = r_distance;
    assign o_flags    = r_flags;

endmodule

### hdl/circle_zone_evaluator.sv
// ----------------------------------------------------------------------------
// circle_zone_evaluator
// Tests position samples against a configured circle and border band.
// Input stream: i_s_tdata carries pos_x and pos_y. Output stream: o_m_tdata
// carries inside_res, on_border and distance. The config channel writes
// center_x, center_y, radius and border_margin by index 0 to 3; it is
// always ready; the user must write it only while no sample is in flight,
// as the block does not enforce this. Throughput is one sample per cycle
// while the receiver keeps i_m_tready high. From input to output valid a
// sample passes three difference/square/sum stages, one square root cell
// per result bit (COORD_WIDTH + 1 of them), and the output register.
// Every stage has its own valid bit and takes new data when it is empty or
// its successor moves, so a stalled receiver only backs up the pipeline
// stage by stage; o_s_tready drops once every stage holds a sample.
// Reset clears all stage valid bits and sets all config registers to 0.
// ----------------------------------------------------------------------------
module circle_zone_evaluator #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // pos_x, pos_y
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]          i_s_tdata,
    // inside_res, on_border, distance
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    output logic [((COORD_WIDTH+10)/8)*8-1:0]           o_m_tdata,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  czev_pkg::t_cfg_idx                          i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                      i_cfg_data
);
    import czev_pkg::*;

    localparam int NB    = COORD_WIDTH + 1;
    localparam int OUT_W = ((COORD_WIDTH + 10) / 8) * 8;

    logic [NB:0]     w_valid, w_ready;
    logic [NB:0]     w_rem   [NB+1];
    logic [NB-1:0]   w_root  [NB+1];
    logic [2*NB-1:0] w_rad   [NB+1];
    t_flags          w_flags [NB+1];

    logic [COORD_WIDTH-2:0] w_radius;
    logic [NB-1:0]          w_distance;
    t_flags                 w_out_flags;

    czev_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_pos_x     (i_s_tdata[COORD_WIDTH-1:0]),
        .i_pos_y     (i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .o_valid     (w_valid[0]),
        .i_ready     (w_ready[0]),
        .o_rad       (w_rad[0]),
        .o_flags     (w_flags[0]),
        .o_radius    (w_radius)
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < NB; k++) begin : g_cells
        czev_root_cell #(
            .NB (NB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .i_rad   (w_rad[k]),
            .i_flags (w_flags[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1]),
            .o_rad   (w_rad[k+1]),
            .o_flags (w_flags[k+1])
        );
    end

    czev_back #(
        .NB (NB)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[NB]),
        .o_ready    (w_ready[NB]),
        .i_root     (w_root[NB]),
        .i_flags    (w_flags[NB]),
        .i_radius   (w_radius),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_distance (w_distance),
        .o_flags    (w_out_flags)
    );

    assign o_m_tdata = OUT_W'({w_distance, w_out_flags.on_border, w_out_flags.inside_res});

endmodule

### dv/circle_zone_evaluator_checker.sv
// ----------------------------------------------------------------------------
// circle zone evaluator checker
// Watches the sample, result and register channels of the evaluator. Each
// accepted sample is turned into an expected zone result (inside flag,
// border flag, distance to the circle) from a shadow copy of the circle
// registers. Each accepted result is compared field by field with the oldest
// expected result.
// ----------------------------------------------------------------------------
module circle_zone_evaluator_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    input  logic                                        i_s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]          i_s_tdata,
    input  logic                                        i_m_tvalid,
    input  logic                                        i_m_tready,
    input  logic [((COORD_WIDTH+10)/8)*8-1:0]           i_m_tdata,
    input  logic                                        i_cfg_valid,
    input  logic                                        i_cfg_ready,
    input  czev_pkg::t_cfg_idx                          i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                      i_cfg_data,
    output int                                          o_fail_count,
    output int                                          o_pending,
    output int                                          o_checked,
    output int                                          o_inside,
    output int                                          o_border
);
    import czev_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    typedef struct packed {
        logic [DW-1:0] distance;
        t_flags        flags;
    } t_zone_result;

    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic [COORD_WIDTH-2:0]        radius;
    logic [COORD_WIDTH-2:0]        margin;
    t_zone_result                  zones_due[$];

    function automatic t_zone_result zone_of(input logic [COORD_WIDTH-1:0] px,
                                             input logic [COORD_WIDTH-1:0] py);
        longint       dx;
        longint       dy;
        longint       dist2;
        longint       root;
        longint       cand;
        longint       r;
        longint       half;
        longint       outer;
        longint       inner;
        t_zone_result res;
        dx    = longint'($signed(px)) - longint'(center_x);
        dy    = longint'($signed(py)) - longint'(center_y);
        dist2 = dx * dx + dy * dy;
        root  = 0;
        for (int b = COORD_WIDTH + 1; b >= 0; b--) begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= dist2) root = cand;
        end
        r     = longint'(radius);
        half  = longint'(margin) >> 1;
        outer = r + half;
        inner = (r > half) ? r - half : 0;
        res.flags.inside_res = (dist2 <= r * r);
        res.flags.on_border  = (dist2 <= outer * outer) && (dist2 > inner * inner);
        res.distance         = DW'((root >= r) ? root - r : r - root);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_zone_result got;
        t_zone_result want;
        if (!i_rst_n) begin
            center_x     = '0;
            center_y     = '0;
            radius       = '0;
            margin       = '0;
            zones_due.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_inside     = 0;
            o_border     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CENTER_X:      center_x = i_cfg_data;
                    CFG_CENTER_Y:      center_y = i_cfg_data;
                    CFG_RADIUS:        radius   = i_cfg_data[COORD_WIDTH-2:0];
                    CFG_BORDER_MARGIN: margin   = i_cfg_data[COORD_WIDTH-2:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[DW+1:0];
                if (zones_due.size() == 0) begin
                    $error("result transaction with no sample outstanding: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = zones_due.pop_front();
                    o_checked++;
                    if (want.flags.inside_res) o_inside++;
                    if (want.flags.on_border) o_border++;
                    if (got.flags.inside_res !== want.flags.inside_res) begin
                        $error("inside_res mismatch: expected %0d, actual %0d",
                               want.flags.inside_res, got.flags.inside_res);
                        o_fail_count++;
                    end
                    if (got.flags.on_border !== want.flags.on_border) begin
                        $error("on_border mismatch: expected %0d, actual %0d",
                               want.flags.on_border, got.flags.on_border);
                        o_fail_count++;
                    end
                    if (got.distance !== want.distance) begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               want.distance, got.distance);
                        o_fail_count++;
                    end
                    if ((i_m_tdata >> (DW + 2)) !== '0) begin
                        $error("tdata padding mismatch: expected 0, actual %0h",
                               i_m_tdata >> (DW + 2));
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                zones_due.push_back(zone_of(i_s_tdata[COORD_WIDTH-1:0],
                                            i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
            end
        end
        o_pending = zones_due.size();
    end

endmodule

### dv/circle_zone_evaluator_test.sv
// ----------------------------------------------------------------------------
// circle zone evaluator test
// Drives position samples into the evaluator under a series of circle
// settings: reset values, directed edges of the inside and border tests,
// extreme registers, then random circles with samples aimed at the circle
// and its border band plus full-range noise. Both stream sides idle in
// random bursts, and the receiver holds off long enough to back up the
// pipeline. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module circle_zone_evaluator_test;
    import czev_pkg::*;

    localparam int COORD_WIDTH   = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 125;
    localparam int PHASES        = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [15:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int inside_count;
    int border_count;
    int cycle_count = 0;
    int n_circles   = 1;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;

    always #4 i_clk = ~i_clk;

    circle_zone_evaluator #(
        .COORD_WIDTH (COORD_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    circle_zone_evaluator_checker #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_inside     (inside_count),
        .o_border     (border_count)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: ready bursts, random stalls and the long hold-off
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic [15:0] px, input logic [15:0] py);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic set_circle(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] r, input logic [15:0] m);
        settle();
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_BORDER_MARGIN, m);
        i_cfg_valid <= 1'b0;
        n_circles++;
    endtask

    task automatic run_random_phase(input bit idle_on, input bit with_hold_off);
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] r;
        logic [15:0] m;
        longint      half;
        longint      d;
        longint      dx;
        longint      dy;
        cx = 16'($urandom_range(0, 65535));
        cy = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 2))
            0:       r = 16'($urandom_range(0, 32767));
            1:       r = 16'($urandom_range(0, 400));
            default: r = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       m = 16'd0;
            1:       m = 16'($urandom_range(0, 64));
            2:       m = 16'($urandom_range(0, 2000));
            default: m = 16'($urandom_range(0, 65535));
        endcase
        set_circle(cx, cy, r, m);
        tx_idle_on = idle_on;
        rx_idle_on = idle_on;
        half = longint'(m[14:0]) >> 1;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (with_hold_off && i == PHASE_ITEMS / 4) rx_hold_req = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                // aim at the circle or its border band
                d = longint'(r[14:0]) - half - 2 + $urandom_range(0, int'(2 * half + 4));
                if (d < 0) d = 0;
                dx = $urandom_range(0, int'(d));
                dy = longint'($sqrt(real'(d * d - dx * dx))) + $urandom_range(0, 2) - 1;
                if (dy < 0) dy = 0;
                if ($urandom_range(0, 1)) dx = -dx;
                if ($urandom_range(0, 1)) dy = -dy;
                send_sample(16'(longint'($signed(cx)) + dx), 16'(longint'($signed(cy)) + dy));
            end else begin
                send_sample(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CENTER_X;
        i_cfg_data  = '0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // circle after reset: zero radius at the origin
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000);

        // odd margin: radius 160, half margin 16
        set_circle(16'h0000, 16'h0000, 16'd160, 16'd33);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'd160, 16'h0000);
        send_sample(16'h0000, 16'hFF60);
        send_sample(16'd144, 16'h0000);
        send_sample(16'd145, 16'h0000);
        send_sample(16'd161, 16'h0000);
        send_sample(16'd176, 16'h0000);
        send_sample(16'd177, 16'h0000);

        // margin wider than twice the radius, inner radius clamped
        set_circle(16'd100, 16'hFFCE, 16'd10, 16'd100);
        send_sample(16'd100, 16'hFFCE);
        send_sample(16'd101, 16'hFFCE);
        send_sample(16'd160, 16'hFFCE);

        // extreme registers, radius written with its unused top bit set
        set_circle(16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000);

        for (int p = 0; p < PHASES; p++) begin
            run_random_phase(p != PHASES - 1, p == 1 || p == 3);
        end

        settle();
        $display("%0d samples checked over %0d circle settings", checked, n_circles);
        $display("%0d inside the circle, %0d in the border band", inside_count, border_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
